@@ rtl/core/fft_pkg.sv @@
// shared types and constants for the first-fit resource table
package fft_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CMD_INIT       = 3'd0;
    localparam logic [2:0] CMD_DESTROY    = 3'd1;
    localparam logic [2:0] CMD_REGISTER   = 3'd2;
    localparam logic [2:0] CMD_UNREGISTER = 3'd3;
    localparam logic [2:0] CMD_DISCOVER   = 3'd4;
    localparam logic [2:0] CMD_ALLOCATE   = 3'd5;
    localparam logic [2:0] CMD_RELEASE    = 3'd6;
    localparam logic [2:0] CMD_INFO       = 3'd7;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] res_id;
        logic [7:0]  res_type;
        logic [31:0] capacity;
        logic [31:0] amount;
    } cmd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] out_id;
        logic [7:0]  out_type;
        logic        out_busy;
        logic [31:0] out_capacity;
        logic [31:0] out_used;
        logic [8:0]  match_count;
        logic [31:0] granted_size;
    } rsp_t;
endpackage

@@ rtl/core/first_fit_resource_table.sv @@
// first-fit resource table top level
// One command at a time: an init on an uninitialised table and a destroy on an initialised
// one clear all 256 entries one per cycle. On an initialised table discover scans every entry
// and a command that finds no match does too; a command that hits slot k stops there. The
// table has one read and one write port, read with registered data. The engine takes the
// next command in the cycle after its result is handed to the output register, so a waiting
// result does not hold it up, and a two-entry command queue lets the input side take
// commands while the engine is busy.
module first_fit_resource_table
    import fft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] res_id,
    input  logic [7:0]  res_type,
    input  logic [31:0] capacity,
    input  logic [31:0] amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [31:0] out_id,
    output logic [7:0]  out_type,
    output logic        out_busy,
    output logic [31:0] out_capacity,
    output logic [31:0] out_used,
    output logic [8:0]  match_count,
    output logic [31:0] granted_size
);
    logic push, full, pop, empty;
    cmd_t push_data, pop_data;
    rsp_t rsp;

    fft_front u_front (
        .valid(in_valid), .stall(in_stall),
        .command(command), .res_id(res_id), .res_type(res_type),
        .capacity(capacity), .amount(amount),
        .push(push), .push_data(push_data), .full(full)
    );

    fft_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .pop(pop), .empty(empty), .pop_data(pop_data)
    );

    fft_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .cmd(pop_data), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .rsp(rsp)
    );

    assign ok = rsp.ok;
    assign out_id = rsp.out_id;
    assign out_type = rsp.out_type;
    assign out_busy = rsp.out_busy;
    assign out_capacity = rsp.out_capacity;
    assign out_used = rsp.out_used;
    assign match_count = rsp.match_count;
    assign granted_size = rsp.granted_size;
endmodule

@@ rtl/core/fft_queue.sv @@
// short command queue between front and back
module fft_queue
    import fft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    cmd_t mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0] cnt_reg;

    assign full = cnt_reg == (PW+1)'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end
endmodule

@@ rtl/core/fft_front.sv @@
// input stage: takes commands into the queue
module fft_front
    import fft_pkg::*;
(
    input  logic        valid,
    output logic        stall,
    input  logic [2:0]  command,
    input  logic [31:0] res_id,
    input  logic [7:0]  res_type,
    input  logic [31:0] capacity,
    input  logic [31:0] amount,
    output logic        push,
    output cmd_t        push_data,
    input  logic        full
);
    assign stall = full;
    assign push = valid && !full;
    always_comb
    begin
        push_data.command = command;
        push_data.res_id = res_id;
        push_data.res_type = res_type;
        push_data.capacity = capacity;
        push_data.amount = amount;
    end
endmodule

@@ rtl/core/fft_back.sv @@
// execution engine: scans the table one entry per cycle
module fft_back
    import fft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic empty,
    input  cmd_t cmd,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output rsp_t rsp
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [31:0] ids_mem  [TABLE_ENTRIES];
    logic [7:0]  type_mem [TABLE_ENTRIES];
    logic [31:0] cap_mem  [TABLE_ENTRIES];
    logic [31:0] used_mem [TABLE_ENTRIES];
    logic        busy_mem [TABLE_ENTRIES];

    logic [2:0]  state_reg, state_next;
    logic        ready_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [8:0]  cnt_reg;
    cmd_t        cmd_reg;
    rsp_t        rsp_reg;
    rsp_t        out_rsp_reg;
    logic        vld_reg;

    logic [IDX_W-1:0] ri;
    logic [31:0] r_id, r_cap, r_used;
    logic [7:0]  r_type;
    logic        r_busy;
    logic        rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic        hit;
    logic [31:0] spare;
    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0] wr_id, wr_cap, wr_used;
    logic [7:0]  wr_type;
    logic        wr_busy;
    logic        last;

    assign ri = idx_reg[IDX_W-1:0];
    assign pop = (state_reg == ST_IDLE) && !empty;
    assign out_valid = vld_reg;
    assign rsp = out_rsp_reg;

    always_ff @(posedge clk)
    begin
        r_id <= ids_mem[ri];
        r_type <= type_mem[ri];
        r_cap <= cap_mem[ri];
        r_used <= used_mem[ri];
        r_busy <= busy_mem[ri];
        if (wr_en)
        begin
            ids_mem[wr_idx] <= wr_id;
            type_mem[wr_idx] <= wr_type;
            cap_mem[wr_idx] <= wr_cap;
            used_mem[wr_idx] <= wr_used;
            busy_mem[wr_idx] <= wr_busy;
        end
    end

    assign spare = (r_used > r_cap) ? 32'd0 : r_cap - r_used;
    assign last = rd_idx_reg == IDX_W'(TABLE_ENTRIES-1);

    always_comb
    begin
        unique case (cmd_reg.command)
            CMD_REGISTER:   hit = r_id == '0;
            CMD_ALLOCATE:   hit = r_id != '0 && r_type == cmd_reg.res_type && !r_busy
                                  && spare >= cmd_reg.amount;
            CMD_DISCOVER:   hit = r_id != '0 && r_type == cmd_reg.res_type;
            default:        hit = r_id == cmd_reg.res_id;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_idx = rd_idx_reg;
        wr_id = r_id;
        wr_type = r_type;
        wr_cap = r_cap;
        wr_used = r_used;
        wr_busy = r_busy;
        if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
            wr_idx = ri;
            wr_id = '0;
            wr_type = '0;
            wr_cap = '0;
            wr_used = '0;
            wr_busy = 1'b0;
        end
        else if (state_reg == ST_SCAN && rd_vld_reg && hit)
        begin
            wr_en = 1'b1;
            unique case (cmd_reg.command)
                CMD_REGISTER:
                begin
                    wr_id = cmd_reg.res_id;
                    wr_type = cmd_reg.res_type;
                    wr_cap = cmd_reg.capacity;
                    wr_used = cmd_reg.amount;
                    wr_busy = 1'b0;
                end
                CMD_UNREGISTER:
                begin
                    wr_id = '0;
                    wr_type = '0;
                    wr_cap = '0;
                    wr_used = '0;
                    wr_busy = 1'b0;
                end
                CMD_ALLOCATE:
                begin
                    wr_used = r_used + cmd_reg.amount;
                    wr_busy = 1'b1;
                end
                CMD_RELEASE:
                begin
                    wr_used = (r_used > cmd_reg.amount) ? r_used - cmd_reg.amount : '0;
                    wr_busy = (r_used > cmd_reg.amount) ? r_busy : 1'b0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            vld_reg <= 1'b0;
            idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            cnt_reg <= '0;
            cmd_reg <= '0;
            rsp_reg <= '0;
            out_rsp_reg <= '0;
        end
        else
        begin
            if (vld_reg && !out_stall)
            begin
                vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_vld_reg <= 1'b0;
                    if (pop)
                    begin
                        cmd_reg <= cmd;
                        rsp_reg <= '0;
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        if (cmd.command == CMD_INIT)
                        begin
                            if (!ready_reg)
                            begin
                                ready_reg <= 1'b1;
                                state_reg <= ST_CLEAR;
                            end
                            else
                            begin
                                state_reg <= ST_OUT;
                            end
                        end
                        else if (!ready_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (cmd.command == CMD_DESTROY)
                        begin
                            ready_reg <= 1'b0;
                            state_reg <= ST_CLEAR;
                        end
                        else if (cmd.command == CMD_REGISTER && cmd.res_id == '0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (cmd.command != CMD_REGISTER && cmd.command != CMD_ALLOCATE
                                 && cmd.command != CMD_DISCOVER && cmd.res_id == '0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CNT_W'(TABLE_ENTRIES-1))
                    begin
                        rsp_reg.ok <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_SCAN:
                begin
                    rd_vld_reg <= idx_reg != CNT_W'(TABLE_ENTRIES);
                    if (idx_reg != CNT_W'(TABLE_ENTRIES))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        rd_idx_reg <= ri;
                    end
                    if (rd_vld_reg)
                    begin
                        if (cmd_reg.command == CMD_DISCOVER)
                        begin
                            if (hit)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            if (last)
                            begin
                                rsp_reg.ok <= 1'b1;
                                rsp_reg.match_count <= cnt_reg + 9'(hit);
                                state_reg <= ST_OUT;
                            end
                        end
                        else if (hit)
                        begin
                            rsp_reg.ok <= 1'b1;
                            if (cmd_reg.command == CMD_ALLOCATE)
                            begin
                                rsp_reg.out_id <= r_id;
                                rsp_reg.granted_size <= cmd_reg.amount;
                            end
                            else if (cmd_reg.command == CMD_INFO)
                            begin
                                rsp_reg.out_id <= r_id;
                                rsp_reg.out_type <= r_type;
                                rsp_reg.out_busy <= r_busy;
                                rsp_reg.out_capacity <= r_cap;
                                rsp_reg.out_used <= r_used;
                            end
                            state_reg <= ST_WRITE;
                        end
                        else if (last)
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!vld_reg)
                    begin
                        vld_reg <= 1'b1;
                        out_rsp_reg <= rsp_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && out_stall) |=> (vld_reg && $stable(out_rsp_reg)))
        else $error("stalled result transfer changed");
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> state_reg != ST_IDLE)
        else $error("table written while idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !vld_reg) |=> vld_reg)
        else $error("result not presented");
endmodule
